/* hdl/assert_macros.svh */
// Assertion macros used by the RTL of the palette quantizer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks prop at every rising edge of clk while the active-low reset is released.
`define ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checks prop at every rising edge of clk, during reset as well.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

/* hdl/rgbpq_pkg.sv */
// Constants and helper functions of the RGB to 256-colour palette quantizer.
package rgbpq_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned StepW   = 3;
  localparam int unsigned GreyKW  = 5;
  localparam int unsigned SqW     = 2 * ChanW;
  localparam int unsigned DistW   = SqW + 2;
  localparam int unsigned SumW    = ChanW + 2;
  localparam int unsigned Stages  = 6;

  // Cube step boundaries: below 48 is step 0, below 115 step 1, then every 40.
  localparam logic [ChanW-1:0] CubeThrLo  = 8'd48;
  localparam logic [ChanW-1:0] CubeThr2   = 8'd115;
  localparam logic [ChanW-1:0] CubeThr3   = 8'd155;
  localparam logic [ChanW-1:0] CubeThr4   = 8'd195;
  localparam logic [ChanW-1:0] CubeThr5   = 8'd235;

  // Reciprocal multipliers: x/3 = (x*683)>>11 for x <= 765, x/10 = (x*205)>>11 for x <= 235.
  localparam logic [2*SumW-1:0]  AvgRecip   = 20'd683;
  localparam int unsigned        AvgShift   = 11;
  localparam logic [2*ChanW-1:0] TenRecip   = 16'd205;
  localparam int unsigned        TenShift   = 11;

  localparam logic [ChanW-1:0]  GreyAvgMax   = 8'd238;
  localparam logic [ChanW-1:0]  GreyAvgMin   = 8'd3;
  localparam logic [GreyKW-1:0] GreyLastStep = 5'd23;
  localparam logic [ChanW-1:0]  GreyBase     = 8'd8;
  localparam logic [ChanW-1:0]  GreyBaseIdx  = 8'd232;
  localparam logic [ChanW-1:0]  CubeBaseIdx  = 8'd16;

  // Cube step of one channel value.
  function automatic logic [StepW-1:0] cube_step(input logic [ChanW-1:0] v);
    logic [StepW-1:0] q;
    if (v < CubeThrLo)      q = 3'd0;
    else if (v < CubeThr2)  q = 3'd1;
    else if (v < CubeThr3)  q = 3'd2;
    else if (v < CubeThr4)  q = 3'd3;
    else if (v < CubeThr5)  q = 3'd4;
    else                    q = 3'd5;
    return q;
  endfunction

  // Channel level of a cube step.
  function automatic logic [ChanW-1:0] cube_level(input logic [StepW-1:0] q);
    logic [ChanW-1:0] lv;
    case (q)
      3'd0:    lv = 8'h00;
      3'd1:    lv = 8'h5f;
      3'd2:    lv = 8'h87;
      3'd3:    lv = 8'haf;
      3'd4:    lv = 8'hd7;
      default: lv = 8'hff;
    endcase
    return lv;
  endfunction

  // Absolute difference of two channel values.
  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* hdl/rgb_to_palette256_quantizer_top.sv */
// Top level of the RGB to 256-colour palette quantizer pipeline.
// Maps one 24-bit RGB pixel to the nearest entry of the 256-colour palette (cube
// entries 16 to 231, grey ramp 232 to 255). The block takes one pixel request every
// clock cycle unless the output stalls, and gives its index from a six-stage pipeline
// whose last stage is the output register. The stages are: cube quantization and
// channel sum; cube squares and division of the sum by three; cube distance and grey
// step; grey level and differences; grey squares; final compare. A stall on the
// output freezes the whole pipeline, so the input is stalled in the same cycle while
// a finished result waits; nothing is lost or repeated.
module rgb_to_palette256_quantizer_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [rgbpq_pkg::ChanW-1:0] in_red,
  input  logic [rgbpq_pkg::ChanW-1:0] in_green,
  input  logic [rgbpq_pkg::ChanW-1:0] in_blue,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [rgbpq_pkg::ChanW-1:0] out_palette_index
);
  import rgbpq_pkg::*;

`include "assert_macros.svh"

  // Pipeline control: every stage moves together unless a result is held.
  logic              adv;
  logic [Stages-1:0] valid_r;
  logic [Stages-1:0] valid_nxt;

  assign adv       = !valid_r[Stages-1] || !out_stall;
  assign in_stall  = !adv;
  assign valid_nxt = {valid_r[Stages-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (adv) begin
      valid_r <= valid_nxt;
    end
  end

  // Stage 1: cube steps, distances to the cube levels and the channel sum.
  logic [ChanW-1:0] s1_red_r, s1_green_r, s1_blue_r;
  logic [StepW-1:0] s1_qr_r, s1_qg_r, s1_qb_r;
  logic [ChanW-1:0] s1_dr_r, s1_dg_r, s1_db_r;
  logic [SumW-1:0]  s1_sum_r;
  logic [StepW-1:0] qr_nxt, qg_nxt, qb_nxt;

  assign qr_nxt = cube_step(in_red);
  assign qg_nxt = cube_step(in_green);
  assign qb_nxt = cube_step(in_blue);

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_red_r   <= in_red;
      s1_green_r <= in_green;
      s1_blue_r  <= in_blue;
      s1_qr_r    <= qr_nxt;
      s1_qg_r    <= qg_nxt;
      s1_qb_r    <= qb_nxt;
      s1_dr_r    <= abs_diff(cube_level(qr_nxt), in_red);
      s1_dg_r    <= abs_diff(cube_level(qg_nxt), in_green);
      s1_db_r    <= abs_diff(cube_level(qb_nxt), in_blue);
      s1_sum_r   <= {2'b00, in_red} + {2'b00, in_green} + {2'b00, in_blue};
    end
  end

  // Stage 2: cube squares, cube index and the channel average.
  logic [ChanW-1:0]  s2_red_r, s2_green_r, s2_blue_r;
  logic [SqW-1:0]    s2_sqr_r, s2_sqg_r, s2_sqb_r;
  logic [ChanW-1:0]  s2_cidx_r;
  logic [ChanW-1:0]  s2_avg_r;
  logic [2*SumW-1:0] avg_prod;
  logic [ChanW-1:0]  cidx_nxt;

  assign avg_prod = {{SumW{1'b0}}, s1_sum_r} * AvgRecip;
  assign cidx_nxt = CubeBaseIdx + {5'b0, s1_qr_r} * 8'd36
                  + {5'b0, s1_qg_r} * 8'd6 + {5'b0, s1_qb_r};

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_red_r   <= s1_red_r;
      s2_green_r <= s1_green_r;
      s2_blue_r  <= s1_blue_r;
      s2_sqr_r   <= {{ChanW{1'b0}}, s1_dr_r} * {{ChanW{1'b0}}, s1_dr_r};
      s2_sqg_r   <= {{ChanW{1'b0}}, s1_dg_r} * {{ChanW{1'b0}}, s1_dg_r};
      s2_sqb_r   <= {{ChanW{1'b0}}, s1_db_r} * {{ChanW{1'b0}}, s1_db_r};
      s2_cidx_r  <= cidx_nxt;
      s2_avg_r   <= avg_prod[AvgShift +: ChanW];
    end
  end

  // Stage 3: cube distance and the grey step from the average.
  logic [ChanW-1:0]   s3_red_r, s3_green_r, s3_blue_r;
  logic [DistW-1:0]   s3_dc_r;
  logic [ChanW-1:0]   s3_cidx_r;
  logic [GreyKW-1:0]  s3_k_r;
  logic [ChanW-1:0]   avg_off;
  logic [2*ChanW-1:0] k_prod;
  logic [GreyKW-1:0]  k_nxt;

  assign avg_off = s2_avg_r - GreyAvgMin;
  assign k_prod  = {{ChanW{1'b0}}, avg_off} * TenRecip;

  always_comb begin
    if (s2_avg_r > GreyAvgMax) begin
      k_nxt = GreyLastStep;
    end else if (s2_avg_r < GreyAvgMin) begin
      k_nxt = '0;
    end else begin
      k_nxt = k_prod[TenShift +: GreyKW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_red_r   <= s2_red_r;
      s3_green_r <= s2_green_r;
      s3_blue_r  <= s2_blue_r;
      s3_dc_r    <= {2'b00, s2_sqr_r} + {2'b00, s2_sqg_r} + {2'b00, s2_sqb_r};
      s3_cidx_r  <= s2_cidx_r;
      s3_k_r     <= k_nxt;
    end
  end

  // Stage 4: grey level (8 + 10k) and the channel distances to it.
  logic [DistW-1:0]  s4_dc_r;
  logic [ChanW-1:0]  s4_cidx_r;
  logic [GreyKW-1:0] s4_k_r;
  logic [ChanW-1:0]  s4_dr_r, s4_dg_r, s4_db_r;
  logic [ChanW-1:0]  grey;

  assign grey = GreyBase + {s3_k_r, 3'b000} + {2'b00, s3_k_r, 1'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_dc_r   <= s3_dc_r;
      s4_cidx_r <= s3_cidx_r;
      s4_k_r    <= s3_k_r;
      s4_dr_r   <= abs_diff(grey, s3_red_r);
      s4_dg_r   <= abs_diff(grey, s3_green_r);
      s4_db_r   <= abs_diff(grey, s3_blue_r);
    end
  end

  // Stage 5: grey squares.
  logic [DistW-1:0]  s5_dc_r;
  logic [ChanW-1:0]  s5_cidx_r;
  logic [GreyKW-1:0] s5_k_r;
  logic [SqW-1:0]    s5_sqr_r, s5_sqg_r, s5_sqb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_dc_r   <= s4_dc_r;
      s5_cidx_r <= s4_cidx_r;
      s5_k_r    <= s4_k_r;
      s5_sqr_r  <= {{ChanW{1'b0}}, s4_dr_r} * {{ChanW{1'b0}}, s4_dr_r};
      s5_sqg_r  <= {{ChanW{1'b0}}, s4_dg_r} * {{ChanW{1'b0}}, s4_dg_r};
      s5_sqb_r  <= {{ChanW{1'b0}}, s4_db_r} * {{ChanW{1'b0}}, s4_db_r};
    end
  end

  // Stage 6: the grey wins only when strictly closer than the cube colour.
  logic [DistW-1:0] grey_dist;
  logic [ChanW-1:0] idx_nxt;
  logic [ChanW-1:0] idx_r;

  assign grey_dist = {2'b00, s5_sqr_r} + {2'b00, s5_sqg_r} + {2'b00, s5_sqb_r};
  assign idx_nxt   = (grey_dist < s5_dc_r) ? (GreyBaseIdx + {3'b000, s5_k_r}) : s5_cidx_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      idx_r <= idx_nxt;
    end
  end

  assign out_valid         = valid_r[Stages-1];
  assign out_palette_index = idx_r;

  // A frozen pipeline keeps every stage's valid bit.
  `ASSERT_RST(a_freeze_holds, clk, rst_n, !adv |=> $stable(valid_r))
  // Any index given lies in the cube or the grey ramp.
  `ASSERT_RST(a_index_range, clk, rst_n, out_valid |-> out_palette_index >= CubeBaseIdx)
  // The grey step never passes the last grey.
  `ASSERT_RST(a_grey_step, clk, rst_n, valid_r[Stages-2] |-> s5_k_r <= GreyLastStep)
  // Reset empties the pipeline.
  `ASSERT_ALWAYS(a_reset_empty, clk, !$past(rst_n) |-> valid_r == '0)

endmodule

/* tb/palette_index_checker.sv */
// Checker that predicts the palette index of each pixel request and compares the results.
`timescale 1ns / 1ps

module palette_index_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [rgbpq_pkg::ChanW-1:0] in_red,
  input  logic [rgbpq_pkg::ChanW-1:0] in_green,
  input  logic [rgbpq_pkg::ChanW-1:0] in_blue,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [rgbpq_pkg::ChanW-1:0] out_palette_index,
  output int                          fail_count,
  output int                          pending_count
);

  typedef logic [rgbpq_pkg::ChanW-1:0] chan_t;

  // Cube level boundaries and the linear part above them.
  localparam int LevelOneFrom   = 48;
  localparam int LevelLinearFrom = 114;
  localparam int LevelOffset    = 35;
  localparam int LevelSpacing   = 40;
  localparam int TopCubeStep    = 5;

  // Grey ramp limits and the first palette entry of each region.
  localparam int GreyAvgCeil    = 238;
  localparam int GreyAvgFloor   = 3;
  localparam int GreyTopStep    = 23;
  localparam int GreyFirstLevel = 8;
  localparam int GreySpacing    = 10;
  localparam int GreyFirstEntry = 232;
  localparam int CubeFirstEntry = 16;

  // Indexes still owed by the block, oldest first.
  chan_t expected_index_q[$];

  // Cube step of one channel value.
  function automatic int step_of_channel(input chan_t v);
    int q;
    if (v < LevelOneFrom)         q = 0;
    else if (v < LevelLinearFrom) q = 1;
    else                          q = (int'(v) - LevelOffset) / LevelSpacing;
    if (q > TopCubeStep) q = TopCubeStep;
    return q;
  endfunction

  // Channel intensity of one cube step.
  function automatic int intensity_of_step(input int q);
    int lv;
    case (q)
      0:       lv = 'h00;
      1:       lv = 'h5f;
      2:       lv = 'h87;
      3:       lv = 'haf;
      4:       lv = 'hd7;
      default: lv = 'hff;
    endcase
    return lv;
  endfunction

  function automatic int squared_gap(input int a, input int b);
    return (a - b) * (a - b);
  endfunction

  // Nearest palette entry: the grey only wins when it is strictly closer than the cube colour.
  function automatic chan_t nearest_palette_entry(input chan_t r, input chan_t g,
                                                  input chan_t b);
    int qr, qg, qb;
    int avg, k, grey;
    int cube_dist, grey_dist;
    qr = step_of_channel(r);
    qg = step_of_channel(g);
    qb = step_of_channel(b);
    avg = (int'(r) + int'(g) + int'(b)) / 3;
    if (avg > GreyAvgCeil)       k = GreyTopStep;
    else if (avg < GreyAvgFloor) k = 0;
    else                         k = (avg - GreyAvgFloor) / GreySpacing;
    grey = GreyFirstLevel + GreySpacing * k;
    cube_dist = squared_gap(intensity_of_step(qr), r) + squared_gap(intensity_of_step(qg), g)
              + squared_gap(intensity_of_step(qb), b);
    grey_dist = squared_gap(grey, r) + squared_gap(grey, g) + squared_gap(grey, b);
    if (grey_dist < cube_dist) return chan_t'(GreyFirstEntry + k);
    return chan_t'(CubeFirstEntry + 36 * qr + 6 * qg + qb);
  endfunction

  // Record each accepted request and compare each accepted result with the oldest prediction.
  always @(posedge clk) begin : watch
    chan_t want;
    if (!rst_n) begin
      fail_count    <= 0;
      pending_count <= 0;
    end else begin
      if (in_valid && !in_stall)
        expected_index_q.push_back(nearest_palette_entry(in_red, in_green, in_blue));
      if (out_valid && !out_stall) begin
        if (expected_index_q.size() == 0) begin
          $error("palette_index %0d given with no request outstanding", out_palette_index);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_index_q.pop_front();
          if (want !== out_palette_index) begin
            $error("palette_index mismatch: expected %0d, actual %0d", want,
                   out_palette_index);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= expected_index_q.size();
    end
  end

endmodule

/* tb/tb_rgb_to_palette256_quantizer_top.sv */
// Testbench top of the palette quantizer: pixel stimulus, output stalls, watchdog and verdict.
`timescale 1ns / 1ps

module tb_rgb_to_palette256_quantizer_top;

  typedef logic [rgbpq_pkg::ChanW-1:0] chan_t;

  localparam int RandomPixels  = 1250;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 20;
  localparam int PhaseLength   = 150;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  chan_t in_red;
  chan_t in_green;
  chan_t in_blue;
  logic  out_valid;
  logic  out_stall;
  chan_t out_palette_index;

  int fail_count;
  int pending_count;
  int idle_cycles;
  int stall_left;
  bit calm_sender;
  bit calm_receiver;

  // Values around the cube thresholds, the cube levels and the grey limits.
  chan_t boundary_vals [0:31] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd8, 8'd12, 8'd47,
                                  8'd48, 8'd49, 8'd94, 8'd95, 8'd96, 8'd113, 8'd114, 8'd115,
                                  8'd134, 8'd135, 8'd154, 8'd155, 8'd174, 8'd175, 8'd194,
                                  8'd195, 8'd214, 8'd215, 8'd234, 8'd235, 8'd238, 8'd239,
                                  8'd254, 8'd255};

  rgb_to_palette256_quantizer_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_palette_index (out_palette_index)
  );

  palette_index_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_palette_index (out_palette_index),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Output stalls: mostly short bursts, now and then a long one, none in calm phases.
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (calm_receiver) begin
        out_stall  = 1'b0;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_stall  = 1'b1;
        stall_left = stall_left - 1;
      end else begin
        out_stall = 1'b0;
        if ($urandom_range(0, 99) < 25)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                    : $urandom_range(1, 3);
      end
    end
  end

  // Watchdog: ends the run when no request and no result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Length of the pause after a request: often none, mostly short, sometimes long.
  function automatic int sender_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // A channel value close to a given base, clipped to the channel range.
  function automatic chan_t near_value(input int base);
    int v;
    v = base + $urandom_range(0, 16) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return chan_t'(v);
  endfunction

  // Offers one pixel request, holds it until accepted, then idles for a while.
  task automatic send_pixel(input chan_t r, input chan_t g, input chan_t b);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_red   = r;
    in_green = g;
    in_blue  = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    gap = calm_sender ? 0 : sender_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_red   = chan_t'($urandom);
      in_green = chan_t'($urandom);
      in_blue  = chan_t'($urandom);
    end
  endtask

  // Waits with the input idle until every predicted index has come back.
  task automatic wait_until_drained();
    @(negedge clk);
    in_valid = 1'b0;
    do @(negedge clk); while (pending_count != 0);
  endtask

  // Reset, directed pixels, random pixels, then drain and verdict.
  initial begin
    int    mode;
    int    base;
    chan_t r, g, b;
    in_valid      = 1'b0;
    in_red        = '0;
    in_green      = '0;
    in_blue       = '0;
    rst_n         = 1'b0;
    calm_sender   = 1'b0;
    calm_receiver = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Channel extremes and primaries.
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd200, 8'd0, 8'd200);
    // Exact cube hits give a zero cube distance.
    send_pixel(8'd95, 8'd135, 8'd175);
    send_pixel(8'd215, 8'd255, 8'd95);
    // Equal distances to cube and grey: the cube entry must win.
    send_pixel(8'd4, 8'd4, 8'd4);
    send_pixel(8'd12, 8'd0, 8'd0);
    // Dark averages, below three and around the first grey step.
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd2, 8'd0, 8'd0);
    send_pixel(8'd12, 8'd12, 8'd12);
    send_pixel(8'd13, 8'd13, 8'd13);
    // Bright averages around the top grey.
    send_pixel(8'd238, 8'd238, 8'd238);
    send_pixel(8'd239, 8'd239, 8'd239);
    send_pixel(8'd240, 8'd240, 8'd240);
    // Cube thresholds on every channel.
    send_pixel(8'd47, 8'd48, 8'd113);
    send_pixel(8'd114, 8'd115, 8'd154);
    send_pixel(8'd155, 8'd194, 8'd195);
    send_pixel(8'd234, 8'd235, 8'd254);
    // Greys that should beat the cube.
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd100, 8'd101, 8'd99);
    send_pixel(8'd50, 8'd50, 8'd50);

    // Hold the input off until the pipeline is empty.
    wait_until_drained();

    for (int n = 0; n < RandomPixels; n++) begin
      // Phases: both sides busy, calm sender, calm receiver, both calm.
      calm_sender   = ((n / PhaseLength) % 4) inside {1, 3};
      calm_receiver = ((n / PhaseLength) % 4) inside {2, 3};
      mode = $urandom_range(0, 9);
      if (mode < 4) begin
        r = chan_t'($urandom);
        g = chan_t'($urandom);
        b = chan_t'($urandom);
      end else if (mode < 7) begin
        // Nearly grey pixels, where the grey ramp competes with the cube.
        base = $urandom_range(0, 255);
        r = near_value(base);
        g = near_value(base);
        b = near_value(base);
      end else if (mode < 9) begin
        r = boundary_vals[$urandom_range(0, 31)];
        g = boundary_vals[$urandom_range(0, 31)];
        b = boundary_vals[$urandom_range(0, 31)];
      end else begin
        r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
        b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
      end
      send_pixel(r, g, b);
    end

    calm_sender   = 1'b0;
    calm_receiver = 1'b0;
    wait_until_drained();
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
